/* hdl/tmcl_pkg.sv */
// shared types, constants and helpers of the mip chain layout block
package tmcl_pkg;

  localparam int MAX_DIM    = 16384;
  localparam int MAX_LEVELS = 15;

  localparam int WORD_W     = 32;
  localparam int DIM_W      = 15;
  localparam int ROW_SHIFT  = 8;                       // 256 byte row alignment
  localparam int PIX_SHIFT  = 2;                       // 4 bytes per pixel
  localparam int UNIT_SHIFT = ROW_SHIFT - PIX_SHIFT;   // pixels per 256 byte row unit
  localparam int UNITS_W    = DIM_W - UNIT_SHIFT;
  localparam int PITCH_W    = UNITS_W + ROW_SHIFT;
  localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
  localparam int CHAIN_W    = $clog2(DIM_W + 1);
  localparam int PROD_W     = UNITS_W + DIM_W;
  localparam int GROUP      = 4;
  localparam int NGROUP     = (MAX_LEVELS + GROUP - 1) / GROUP;
  localparam int PAD_LANES  = NGROUP * GROUP;
  localparam int GSUM_W     = PROD_W + $clog2(GROUP);
  localparam int TSUM_W     = PROD_W + $clog2(PAD_LANES);

  typedef enum logic {
    ST_OK      = 1'b0,
    ST_INVALID = 1'b1
  } tmcl_status_t;

  typedef struct packed {
    logic [WORD_W-1:0] tex_width;
    logic [WORD_W-1:0] tex_height;
    logic [WORD_W-1:0] level_count;
    logic [WORD_W-1:0] query_level;
    logic [WORD_W-1:0] declared_pitch;
    logic [WORD_W-1:0] declared_total;
    logic [WORD_W-1:0] reserved_word0;
    logic [WORD_W-1:0] reserved_word1;
    logic [WORD_W-1:0] reserved_word2;
  } tmcl_in_t;

  typedef struct packed {
    logic               status;
    logic [WORD_W-1:0]  mip_offset;
    logic [WORD_W-1:0]  mip_bytes;
    logic [DIM_W-1:0]   mip_width;
    logic [DIM_W-1:0]   mip_height;
    logic [PITCH_W-1:0] mip_pitch;
    logic               layout_valid;
  } tmcl_out_t;

  // per item data that rides along the pipeline beside the lanes
  typedef struct packed {
    logic               q_ok;
    logic               lay_pre;
    logic [WORD_W-1:0]  dtotal;
    logic [DIM_W-1:0]   qw;
    logic [DIM_W-1:0]   qh;
    logic [PITCH_W-1:0] qpitch;
    logic [WORD_W-1:0]  qbytes;
  } tmcl_side_t;

  typedef logic [MAX_LEVELS-1:0][UNITS_W-1:0] tmcl_units_t;
  typedef logic [MAX_LEVELS-1:0][DIM_W-1:0]   tmcl_dims_t;
  typedef logic [MAX_LEVELS-1:0][PROD_W-1:0]  tmcl_prods_t;

  // level dimension, floored at one
  function automatic logic [DIM_W-1:0] dim_at(logic [DIM_W-1:0] b, logic [LVL_W-1:0] k);
    logic [DIM_W-1:0] v;
    v = b >> k;
    if (v == '0) begin
      v = DIM_W'(1);
    end
    return v;
  endfunction

  // number of 256 byte units in one row
  function automatic logic [UNITS_W-1:0] units_of(logic [DIM_W-1:0] d);
    logic [DIM_W:0] t;
    t = {1'b0, d} + (DIM_W + 1)'((1 << UNIT_SHIFT) - 1);
    return UNITS_W'(t >> UNIT_SHIFT);
  endfunction

endpackage

/* hdl/texture_mip_chain_layout.sv */
// top level of the mip chain layout block: pipeline stages and output register
//
// Takes one RGBA8 texture descriptor plus a queried mip level per item on
// the in_ channel (valid/ready) and returns one result item per input on
// the out_ channel (valid/ready), in order. Levels are packed smallest
// first; the result gives the queried level's offset, size, width, height
// and row pitch, a status flag, and a flag for the whole descriptor.
// An accepted item reaches out_valid through five registers: decode, lane
// multiply, two adder tree stages and the output register. One item is
// accepted in every cycle while the receiver takes results, so throughput
// is one item per cycle; the per level products run in parallel lanes,
// one per level.
// Reset (rst_n low at a clock edge) empties all stages; no result is
// pending afterwards. When the receiver holds out_ready low with a result
// waiting, the whole pipeline holds and in_ready drops, so nothing is lost
// or repeated; in_ready returns as soon as the waiting result is taken.
module texture_mip_chain_layout import tmcl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tmcl_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output tmcl_out_t out_data
);

  logic                  en;
  logic                  v1;
  tmcl_side_t            side1;
  tmcl_units_t           units1;
  tmcl_dims_t            lh1;
  logic [MAX_LEVELS-1:0] off_en1;
  logic [MAX_LEVELS-1:0] tot_en1;
  logic                  v2;
  tmcl_side_t            side2;
  tmcl_prods_t           off2;
  tmcl_prods_t           tot2;
  logic                  v4;
  tmcl_side_t            side4;
  logic [TSUM_W-1:0]     off_sum4;
  logic [TSUM_W-1:0]     tot_sum4;
  logic                  out_valid_r;
  tmcl_out_t             out_data_r;
  tmcl_out_t             out_data_nxt;
  logic [WORD_W-1:0]     offset;
  logic [WORD_W-1:0]     total;

  // pipeline advances whenever the output register is free or drains
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  tmcl_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .v_r      (v1),
    .side_r   (side1),
    .units_r  (units1),
    .lh_r     (lh1),
    .off_en_r (off_en1),
    .tot_en_r (tot_en1)
  );

  tmcl_lane_mul u_lane_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_i      (v1),
    .side_i   (side1),
    .units_i  (units1),
    .lh_i     (lh1),
    .off_en_i (off_en1),
    .tot_en_i (tot_en1),
    .v_r      (v2),
    .side_r   (side2),
    .off_r    (off2),
    .tot_r    (tot2)
  );

  tmcl_sum_tree u_sum_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v_i       (v2),
    .side_i    (side2),
    .off_i     (off2),
    .tot_i     (tot2),
    .v_r       (v4),
    .side_r    (side4),
    .off_sum_r (off_sum4),
    .tot_sum_r (tot_sum4)
  );

  // result assembly
  always_comb begin
    offset = WORD_W'({off_sum4, ROW_SHIFT'(0)});
    total  = WORD_W'({tot_sum4, ROW_SHIFT'(0)});
    out_data_nxt.layout_valid = side4.lay_pre && (side4.dtotal == total);
    if (side4.q_ok) begin
      out_data_nxt.status     = ST_OK;
      out_data_nxt.mip_offset = offset;
      out_data_nxt.mip_bytes  = side4.qbytes;
      out_data_nxt.mip_width  = side4.qw;
      out_data_nxt.mip_height = side4.qh;
      out_data_nxt.mip_pitch  = side4.qpitch;
    end else begin
      out_data_nxt.status     = ST_INVALID;
      out_data_nxt.mip_offset = '0;
      out_data_nxt.mip_bytes  = '0;
      out_data_nxt.mip_width  = '0;
      out_data_nxt.mip_height = '0;
      out_data_nxt.mip_pitch  = '0;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/tmcl_decode.sv */
// first stage: descriptor checks, chain length and per level dimensions
module tmcl_decode import tmcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  tmcl_in_t    in_data,
  output logic        v_r,
  output tmcl_side_t  side_r,
  output tmcl_units_t units_r,
  output tmcl_dims_t  lh_r,
  output logic [MAX_LEVELS-1:0] off_en_r,
  output logic [MAX_LEVELS-1:0] tot_en_r
);

  logic                  dims_ok;
  logic                  cnt_ok;
  logic                  base_ok;
  logic [DIM_W-1:0]      w_s;
  logic [DIM_W-1:0]      h_s;
  logic [DIM_W-1:0]      m_s;
  logic [CHAIN_W-1:0]    chain;
  logic [LVL_W-1:0]      lq;
  logic [PITCH_W-1:0]    pitch0;
  tmcl_side_t            side_nxt;
  tmcl_units_t           units_nxt;
  tmcl_dims_t            lh_nxt;
  logic [MAX_LEVELS-1:0] off_en_nxt;
  logic [MAX_LEVELS-1:0] tot_en_nxt;

  // range checks and chain length
  always_comb begin
    dims_ok = (in_data.tex_width != '0) && (in_data.tex_height != '0) &&
              (in_data.tex_width <= WORD_W'(MAX_DIM)) &&
              (in_data.tex_height <= WORD_W'(MAX_DIM));
    cnt_ok  = (in_data.level_count != '0) &&
              (in_data.level_count <= WORD_W'(MAX_LEVELS));
    base_ok = dims_ok && cnt_ok;
    w_s     = in_data.tex_width[DIM_W-1:0];
    h_s     = in_data.tex_height[DIM_W-1:0];
    m_s     = (w_s > h_s) ? w_s : h_s;
    chain   = '0;
    for (int i = 0; i < DIM_W; i++) begin
      if (m_s[i]) begin
        chain = CHAIN_W'(i + 1);
      end
    end
    lq     = in_data.query_level[LVL_W-1:0];
    pitch0 = {units_of(w_s), ROW_SHIFT'(0)};
  end

  // side data and lanes
  always_comb begin
    side_nxt.q_ok    = base_ok && (in_data.query_level < in_data.level_count);
    side_nxt.lay_pre = base_ok &&
                       (in_data.level_count == WORD_W'(chain)) &&
                       (in_data.declared_pitch == WORD_W'(pitch0)) &&
                       (in_data.reserved_word0 == '0) &&
                       (in_data.reserved_word1 == '0) &&
                       (in_data.reserved_word2 == '0);
    side_nxt.dtotal  = in_data.declared_total;
    side_nxt.qw      = dim_at(w_s, lq);
    side_nxt.qh      = dim_at(h_s, lq);
    side_nxt.qpitch  = {units_of(side_nxt.qw), ROW_SHIFT'(0)};
    side_nxt.qbytes  = '0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      units_nxt[k]  = units_of(dim_at(w_s, LVL_W'(k)));
      lh_nxt[k]     = dim_at(h_s, LVL_W'(k));
      tot_en_nxt[k] = WORD_W'(k) < in_data.level_count;
      off_en_nxt[k] = (WORD_W'(k) > in_data.query_level) && tot_en_nxt[k];
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_r   <= side_nxt;
      units_r  <= units_nxt;
      lh_r     <= lh_nxt;
      off_en_r <= off_en_nxt;
      tot_en_r <= tot_en_nxt;
    end
  end

endmodule

/* hdl/tmcl_lane_mul.sv */
// second stage: one multiplier per level lane plus the queried level's size
module tmcl_lane_mul import tmcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        v_i,
  input  tmcl_side_t  side_i,
  input  tmcl_units_t units_i,
  input  tmcl_dims_t  lh_i,
  input  logic [MAX_LEVELS-1:0] off_en_i,
  input  logic [MAX_LEVELS-1:0] tot_en_i,
  output logic        v_r,
  output tmcl_side_t  side_r,
  output tmcl_prods_t off_r,
  output tmcl_prods_t tot_r
);

  tmcl_side_t        side_nxt;
  tmcl_prods_t       off_nxt;
  tmcl_prods_t       tot_nxt;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] qprod;

  // row units times height, masked per sum
  always_comb begin
    prod = '0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      prod       = PROD_W'(units_i[k]) * PROD_W'(lh_i[k]);
      off_nxt[k] = off_en_i[k] ? prod : '0;
      tot_nxt[k] = tot_en_i[k] ? prod : '0;
    end
    qprod           = PROD_W'(side_i.qpitch[PITCH_W-1:ROW_SHIFT]) * PROD_W'(side_i.qh);
    side_nxt        = side_i;
    side_nxt.qbytes = WORD_W'({qprod, ROW_SHIFT'(0)});
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      off_r  <= off_nxt;
      tot_r  <= tot_nxt;
    end
  end

endmodule

/* hdl/tmcl_sum_tree.sv */
// third and fourth stages: registered adder tree over the level lanes
module tmcl_sum_tree import tmcl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_i,
  input  tmcl_side_t        side_i,
  input  tmcl_prods_t       off_i,
  input  tmcl_prods_t       tot_i,
  output logic              v_r,
  output tmcl_side_t        side_r,
  output logic [TSUM_W-1:0] off_sum_r,
  output logic [TSUM_W-1:0] tot_sum_r
);

  logic                           va_r;
  tmcl_side_t                     sidea_r;
  logic [NGROUP-1:0][GSUM_W-1:0]  goff_r;
  logic [NGROUP-1:0][GSUM_W-1:0]  gtot_r;
  logic [NGROUP-1:0][GSUM_W-1:0]  goff_nxt;
  logic [NGROUP-1:0][GSUM_W-1:0]  gtot_nxt;
  logic [TSUM_W-1:0]              off_sum_nxt;
  logic [TSUM_W-1:0]              tot_sum_nxt;

  // group sums of up to four lanes
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      goff_nxt[g] = '0;
      gtot_nxt[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < MAX_LEVELS) begin
          goff_nxt[g] = goff_nxt[g] + GSUM_W'(off_i[g * GROUP + j]);
          gtot_nxt[g] = gtot_nxt[g] + GSUM_W'(tot_i[g * GROUP + j]);
        end
      end
    end
  end

  // final sum over the groups
  always_comb begin
    off_sum_nxt = '0;
    tot_sum_nxt = '0;
    for (int g = 0; g < NGROUP; g++) begin
      off_sum_nxt = off_sum_nxt + TSUM_W'(goff_r[g]);
      tot_sum_nxt = tot_sum_nxt + TSUM_W'(gtot_r[g]);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      v_r  <= 1'b0;
    end else if (en) begin
      va_r <= v_i;
      v_r  <= va_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      sidea_r   <= side_i;
      goff_r    <= goff_nxt;
      gtot_r    <= gtot_nxt;
      side_r    <= sidea_r;
      off_sum_r <= off_sum_nxt;
      tot_sum_r <= tot_sum_nxt;
    end
  end

endmodule
